// ===== hw/rtl/pfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// types, character codes and helpers shared by the format engine modules
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned DIG_DEPTH = 10;
  localparam int unsigned DIG_IDX_W = $clog2(DIG_DEPTH);

  localparam logic [WORD_W-1:0] COUNT_MAX = '1;
  localparam logic [WORD_W-1:0] RECIP_10  = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SH  = 35;

  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] ASCII_0  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_A10 = 8'd87;

  typedef struct packed {
    logic [CHAR_W-1:0] fmt_char;
    logic [WORD_W-1:0] arg_value;
    logic              start_new;
  } pfe_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_of_run;
    logic [WORD_W-1:0] chars_written;
  } pfe_out_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ONE,
    ACT_NUM
  } act_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_SINGLE,
    LD_MINUS,
    LD_DIGIT
  } ld_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT_ONE,
    ST_SIGN,
    ST_DIG
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    conv_step;
    ld_sel_t load_sel;
    logic    last;
  } pfe_cmd_t;

  typedef struct packed {
    act_t act;
    logic neg;
    logic conv_done;
    logic dig_last;
    logic load_ok;
  } pfe_sts_t;

  function automatic logic [CHAR_W-1:0] dig_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dz;
    dz = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    return (d < 4'd10) ? (dz + ASCII_0) : (dz + ASCII_A10);
  endfunction

endpackage

// ===== hw/rtl/pfe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl
// sequencer: takes a format character, runs digit extraction, emits characters
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              fmt_valid,
  output logic              fmt_ready,
  input  pfe_pkg::pfe_sts_t sts,
  output pfe_pkg::pfe_cmd_t cmd
);
  import pfe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    fmt_ready     = 1'b0;
    cmd.accept    = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.load_sel  = LD_NONE;
    cmd.last      = 1'b0;
    case (state)
      ST_IDLE: begin
        fmt_ready = 1'b1;
        if (fmt_valid) begin
          cmd.accept = 1'b1;
          case (sts.act)
            ACT_ONE: state_next = ST_EMIT_ONE;
            ACT_NUM: state_next = ST_CONV;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_next = sts.neg ? ST_SIGN : ST_DIG;
        end
      end
      ST_EMIT_ONE: begin
        if (sts.load_ok) begin
          cmd.load_sel = LD_SINGLE;
          cmd.last     = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (sts.load_ok) begin
          cmd.load_sel = LD_MINUS;
          state_next   = ST_DIG;
        end
      end
      ST_DIG: begin
        if (sts.load_ok) begin
          cmd.load_sel = LD_DIGIT;
          cmd.last     = sts.dig_last;
          if (sts.dig_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_sel != LD_NONE) |-> sts.load_ok)
    else $error("character loaded while output slot busy");

  a_silent_item_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.act == ACT_NONE) |=> (state == ST_IDLE))
    else $error("silent item left the idle state");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_sel != LD_NONE && cmd.last) |=> (state == ST_IDLE))
    else $error("last character did not end the run");

  a_minus_only_negative: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_sel == LD_MINUS) |-> sts.neg)
    else $error("minus sign for a non-negative value");
`endif

endmodule

// ===== hw/rtl/pfe_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_dpath
// specifier decode, digit extraction, digit buffer, count and output register
// ----------------------------------------------------------------------------
module pfe_dpath (
  input  logic              clk,
  input  logic              rst,
  input  pfe_pkg::pfe_in_t  fmt_item,
  input  pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_sts_t sts,
  output logic              chr_valid,
  input  logic              chr_ready,
  output pfe_pkg::pfe_out_t chr_item
);
  import pfe_pkg::*;

  logic                 pending;
  logic                 pending_next;
  logic [WORD_W-1:0]    count;
  logic [WORD_W-1:0]    count_inc;
  logic [WORD_W-1:0]    value;
  logic                 hex;
  logic                 neg;
  logic [CHAR_W-1:0]    single;
  logic [DIGIT_W-1:0]   digits [DIG_DEPTH];
  logic [DIG_IDX_W-1:0] cnt;
  logic [DIG_IDX_W-1:0] ptr;

  act_t                 act;
  logic                 dec_neg;
  logic                 dec_hex;
  logic [CHAR_W-1:0]    dec_char;
  logic                 eff_pending;

  logic [2*WORD_W-1:0]  prod;
  logic [WORD_W-1:0]    quot;
  logic [WORD_W-1:0]    quot10;
  logic [DIGIT_W-1:0]   digit;
  logic [CHAR_W-1:0]    ld_char;
  logic                 load;

  // item decode against the pending flag
  always_comb begin
    eff_pending  = pending & ~fmt_item.start_new;
    act          = ACT_NONE;
    dec_neg      = 1'b0;
    dec_hex      = 1'b0;
    dec_char     = fmt_item.fmt_char;
    pending_next = 1'b0;
    if (eff_pending) begin
      case (fmt_item.fmt_char)
        CH_PCT: act = ACT_ONE;
        CH_D: begin
          act     = ACT_NUM;
          dec_neg = fmt_item.arg_value[WORD_W-1];
        end
        CH_U: act = ACT_NUM;
        CH_X: begin
          act     = ACT_NUM;
          dec_hex = 1'b1;
        end
        CH_C: begin
          act      = ACT_ONE;
          dec_char = fmt_item.arg_value[CHAR_W-1:0];
        end
        default: act = ACT_NONE;
      endcase
    end else if (fmt_item.fmt_char == CH_PCT) begin
      pending_next = 1'b1;
    end else begin
      act = ACT_ONE;
    end
  end

  // one digit per step: reciprocal multiply for base ten, shift for base 16
  always_comb begin
    prod   = {{WORD_W{1'b0}}, value} * {{WORD_W{1'b0}}, RECIP_10};
    quot10 = '0;
    if (hex) begin
      quot  = {4'd0, value[WORD_W-1:DIGIT_W]};
      digit = value[DIGIT_W-1:0];
    end else begin
      quot   = {{(RECIP_SH-WORD_W){1'b0}}, prod[2*WORD_W-1:RECIP_SH]};
      quot10 = {quot[WORD_W-4:0], 3'b000} + {quot[WORD_W-2:0], 1'b0};
      digit  = value[DIGIT_W-1:0] - quot10[DIGIT_W-1:0];
    end
  end

  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;
  assign load      = (cmd.load_sel != LD_NONE);

  always_comb begin
    case (cmd.load_sel)
      LD_SINGLE: ld_char = single;
      LD_MINUS:  ld_char = CH_MINUS;
      LD_DIGIT:  ld_char = dig_ascii(digits[ptr]);
      default:   ld_char = single;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      count     <= '0;
      chr_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pending <= pending_next;
        if (fmt_item.start_new) begin
          count <= '0;
        end
      end else if (load) begin
        count <= count_inc;
      end
      if (load) begin
        chr_valid <= 1'b1;
      end else if (chr_ready) begin
        chr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      value  <= dec_neg ? (~fmt_item.arg_value + 1'b1) : fmt_item.arg_value;
      hex    <= dec_hex;
      neg    <= dec_neg;
      single <= dec_char;
      cnt    <= '0;
    end
    if (cmd.conv_step) begin
      digits[cnt] <= digit;
      cnt         <= cnt + 1'b1;
      ptr         <= cnt;
      value       <= quot;
    end
    if (cmd.load_sel == LD_DIGIT) begin
      ptr <= ptr - 1'b1;
    end
    if (load) begin
      chr_item.out_char      <= ld_char;
      chr_item.last_of_run   <= cmd.last;
      chr_item.chars_written <= count_inc;
    end
  end

  assign sts.act       = act;
  assign sts.neg       = neg;
  assign sts.conv_done = (quot == '0);
  assign sts.dig_last  = (ptr == '0);
  assign sts.load_ok   = ~chr_valid | chr_ready;

endmodule

// ===== hw/rtl/printf_format_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_format_engine_core
// integer formatting engine: format characters in, output characters out
// ----------------------------------------------------------------------------
//
//  channel | direction | payload    | handshake
//  --------+-----------+------------+----------------------
//  fmt     | in        | pfe_in_t   | fmt_valid / fmt_ready
//  chr     | out       | pfe_out_t  | chr_valid / chr_ready
//
//  one format character per transfer, taken only while the sequencer is idle
//  a plain character, %% or %c is accepted, then emitted as one character; an
//    arming percent or an unknown specifier is only accepted
//  a number with n digits is accepted, then takes n conversion steps, one
//    per digit from the reciprocal multiply (or nibble shift) unit, then
//    the minus sign if negative and the n digits are emitted, the longest
//    run being "-2147483648"; every emit waits while the output register
//    still holds a character not yet taken
//  output register decouples the sides: the next format character is taken
//    while the last character of the previous run still waits on chr_ready
//  synchronous reset clears the pending flag, the running count and state
//
module printf_format_engine_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fmt_valid,
  output logic              fmt_ready,
  input  pfe_pkg::pfe_in_t  fmt_item,
  output logic              chr_valid,
  input  logic              chr_ready,
  output pfe_pkg::pfe_out_t chr_item
);
  import pfe_pkg::*;

  // command and status between sequencer and datapath
  pfe_cmd_t cmd;
  pfe_sts_t sts;

  // sequencer: idle, digit extraction, single-character emit, sign, digit emit
  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fmt_valid (fmt_valid),
    .fmt_ready (fmt_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: decode, digit buffer, running count, output register
  pfe_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .fmt_item  (fmt_item),
    .cmd       (cmd),
    .sts       (sts),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_item  (chr_item)
  );

endmodule

// ===== bench/printf_format_engine_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printf_format_engine_core_tb
// self-checking bench: format characters go in over the fmt channel, every
// output character is scored against golden text or a running model of the formatter
// ----------------------------------------------------------------------------
module printf_format_engine_core_tb;
  import pfe_pkg::*;

  // receiver hold-off used to back the engine up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  // quiet cycles after the last character, to catch stray output
  localparam int unsigned TAIL_CYCLES = 50;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     fmt_valid = 1'b0;
  logic     fmt_ready;
  pfe_in_t  fmt_item  = '0;
  logic     chr_valid;
  logic     chr_ready = 1'b0;
  pfe_out_t chr_item;

  // idle and stall odds, percent per cycle
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // hold-off requests: the stimulus bumps hold_asks, the receiver counts
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int errors = 0;

  // formatter model state
  logic              pending_spec  = 1'b0;
  logic [WORD_W-1:0] emitted_total = '0;

  // characters caused by the current format character, and all still owed
  pfe_out_t step_chars[$];
  pfe_out_t expected_chars[$];

  // directed stimulus; golden text is given only where it is obvious
  typedef struct {
    pfe_in_t     item;
    bit          typed;
    string       golden;
    int unsigned first_count;
  } stim_row_t;

  stim_row_t directed_rows[$];

  printf_format_engine_core dut (
    .clk       (clk),
    .rst       (rst),
    .fmt_valid (fmt_valid),
    .fmt_ready (fmt_ready),
    .fmt_item  (fmt_item),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_item  (chr_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the engine hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // formatter model
  // ---------------------------------------------------------------------------

  // one output character, running count saturates at all ones
  function automatic void emit_char(input logic [CHAR_W-1:0] ch);
    pfe_out_t c;
    if (emitted_total != COUNT_MAX) begin
      emitted_total = emitted_total + 1'b1;
    end
    c.out_char      = ch;
    c.last_of_run   = 1'b0;
    c.chars_written = emitted_total;
    step_chars.push_back(c);
  endfunction

  // works out the characters one format character causes
  function automatic void format_char(input pfe_in_t it);
    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] radix;
    logic [WORD_W-1:0] dig;
    logic [CHAR_W-1:0] digits[$];
    step_chars.delete();
    if (it.start_new) begin
      emitted_total = '0;
      pending_spec  = 1'b0;
    end
    if (pending_spec) begin
      pending_spec = 1'b0;
      case (it.fmt_char)
        CH_PCT: begin
          emit_char(CH_PCT);
        end
        CH_D, CH_U, CH_X: begin
          mag   = it.arg_value;
          radix = (it.fmt_char == CH_X) ? 32'd16 : 32'd10;
          // signed decimal prints the magnitude after a minus sign
          if (it.fmt_char == CH_D && mag[WORD_W-1]) begin
            emit_char(CH_MINUS);
            mag = ~mag + 1'b1;
          end
          // a zero value still gives one digit
          do begin
            dig = mag % radix;
            digits.push_front((dig < 32'd10) ? CHAR_W'(dig) + ASCII_0
                                             : CHAR_W'(dig) + ASCII_A10);
            mag = mag / radix;
          end while (mag != '0);
          foreach (digits[k]) begin
            emit_char(digits[k]);
          end
        end
        CH_C: begin
          emit_char(it.arg_value[CHAR_W-1:0]);
        end
        default: begin
          // unknown specifier: swallowed
        end
      endcase
    end else if (it.fmt_char == CH_PCT) begin
      pending_spec = 1'b1;
    end else begin
      emit_char(it.fmt_char);
    end
    if (step_chars.size() > 0) begin
      step_chars[step_chars.size()-1].last_of_run = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_row(input logic [CHAR_W-1:0] ch, input logic [WORD_W-1:0] arg,
                                  input logic sn, input bit typed, input string golden,
                                  input int unsigned first_count);
    stim_row_t r;
    r.item.fmt_char  = ch;
    r.item.arg_value = arg;
    r.item.start_new = sn;
    r.typed          = typed;
    r.golden         = golden;
    r.first_count    = first_count;
    directed_rows.push_back(r);
  endfunction

  // arguments weighted toward the interesting magnitudes
  function automatic logic [WORD_W-1:0] pick_arg();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return WORD_W'($urandom_range(9));
      4:       return WORD_W'($urandom_range(99999));
      5:       return WORD_W'(0) - WORD_W'($urandom_range(100000));
      default: return $urandom();
    endcase
  endfunction

  // one fmt transfer, with random idle cycles ahead of it, then the
  // characters it owes are queued (golden text if given, else the model)
  task automatic offer_char(input pfe_in_t it, input bit typed, input string golden,
                            input int unsigned first_count);
    pfe_out_t c;
    while ($urandom_range(99) < idle_pct) begin
      fmt_valid <= 1'b0;
      @(posedge clk);
    end
    fmt_valid <= 1'b1;
    fmt_item  <= it;
    @(posedge clk);
    while (!fmt_ready) @(posedge clk);
    // transfer done at this edge; its characters cannot show up before the next
    format_char(it);
    if (typed) begin
      for (int i = 0; i < golden.len(); i++) begin
        c.out_char      = golden[i];
        c.last_of_run   = (i == golden.len() - 1);
        c.chars_written = WORD_W'(first_count + i);
        expected_chars.push_back(c);
      end
    end else begin
      foreach (step_chars[k]) begin
        expected_chars.push_back(step_chars[k]);
      end
    end
  endtask

  // mostly well-formed specifier pairs, some plain text, some junk
  task automatic random_burst(inout int unsigned sent);
    pfe_in_t     it;
    int unsigned pick;
    pick         = $urandom_range(99);
    it.start_new = ($urandom_range(19) == 0);
    it.arg_value = pick_arg();
    if (pick < 60) begin
      it.fmt_char = CH_PCT;
      offer_char(it, 1'b0, "", 0);
      case ($urandom_range(5))
        0:       it.fmt_char = CH_PCT;
        1, 2:    it.fmt_char = CH_D;
        3:       it.fmt_char = CH_U;
        4:       it.fmt_char = CH_X;
        default: it.fmt_char = CH_C;
      endcase
      it.start_new = 1'b0;
      it.arg_value = pick_arg();
      offer_char(it, 1'b0, "", 0);
      sent += 2;
    end else if (pick < 85) begin
      // any byte, a stray percent arms the next one
      it.fmt_char = CHAR_W'($urandom_range(255));
      offer_char(it, 1'b0, "", 0);
      sent += 1;
    end else begin
      // percent then an arbitrary byte, possibly cut off by start_new
      it.fmt_char = CH_PCT;
      offer_char(it, 1'b0, "", 0);
      it.fmt_char  = CHAR_W'($urandom_range(255));
      it.start_new = $urandom_range(1);
      it.arg_value = $urandom();
      offer_char(it, 1'b0, "", 0);
      sent += 2;
    end
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls, hold-off on request, scoring
  // ---------------------------------------------------------------------------

  task automatic check_char(input pfe_out_t got);
    pfe_out_t want;
    if (expected_chars.size() == 0) begin
      $error("unexpected output character: got %h", got.out_char);
      errors++;
    end else begin
      want = expected_chars.pop_front();
      if (got.out_char !== want.out_char) begin
        $error("out_char: expected %h, got %h", want.out_char, got.out_char);
        errors++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
        errors++;
      end
      if (got.chars_written !== want.chars_written) begin
        $error("chars_written: expected %0d, got %0d", want.chars_written,
               got.chars_written);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      chr_ready <= 1'b0;
    end else begin
      chr_ready <= ($urandom_range(99) >= stall_pct);
    end
    // ready and valid here are the values before this edge
    if (!rst && chr_valid && chr_ready) begin
      check_char(chr_item);
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned sent;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // plain text, including the NUL and all-ones bytes
    add_row("A",     32'h0000_0000, 1'b1, 1'b1, "A", 1);
    add_row(8'h00,   32'hFFFF_FFFF, 1'b0, 1'b0, "",  0);
    add_row(8'hFF,   32'h0000_0000, 1'b0, 1'b0, "",  0);
    // arming percent emits nothing, a second one prints a percent sign
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_PCT,  32'hFFFF_FFFF, 1'b0, 1'b1, "%", 1);
    // signed decimal: most negative, most positive, zero
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_D,    32'h8000_0000, 1'b0, 1'b1, "-2147483648", 1);
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_D,    32'h7FFF_FFFF, 1'b0, 1'b1, "2147483647", 1);
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_D,    32'h0000_0000, 1'b0, 1'b1, "0", 1);
    // unsigned decimal extremes
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_U,    32'hFFFF_FFFF, 1'b0, 1'b1, "4294967295", 1);
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_U,    32'h0000_0000, 1'b0, 1'b1, "0", 1);
    // hex extremes
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_X,    32'hFFFF_FFFF, 1'b0, 1'b1, "ffffffff", 1);
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_X,    32'h0000_0000, 1'b0, 1'b1, "0", 1);
    // char specifier takes the low byte only
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row(CH_C,    32'h1234_5641, 1'b0, 1'b1, "A", 1);
    // unknown specifier is swallowed
    add_row(CH_PCT,  32'h0000_0000, 1'b1, 1'b1, "",  0);
    add_row("s",     32'hDEAD_BEEF, 1'b0, 1'b1, "",  0);
    // start_new drops a pending specifier, so 'q' prints as text
    add_row(CH_PCT,  32'h0000_0000, 1'b0, 1'b0, "",  0);
    add_row("q",     32'h0000_0000, 1'b1, 1'b1, "q", 1);

    foreach (directed_rows[i]) begin
      offer_char(directed_rows[i].item, directed_rows[i].typed,
                 directed_rows[i].golden, directed_rows[i].first_count);
    end
    fmt_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);

    // random phases: idle and stall odds change, the engine drains in between
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 81; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 81; end
        3: begin idle_pct = 16; stall_pct = 16; end
        default: begin
          // long receiver hold-off while the sender keeps pushing
          idle_pct  = 0;
          stall_pct = 0;
          hold_asks++;
        end
      endcase
      sent = 0;
      while (sent < 45) begin
        random_burst(sent);
      end
      fmt_valid <= 1'b0;
      do @(posedge clk); while (expected_chars.size() != 0);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
